// ----- src/prs80_pkg.sv -----
// ----------------------------------------------------------------------------
// prs80_pkg
// Shared types, constants and round functions for the PRESENT-80 engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package prs80_pkg;

    localparam int BLOCK_W    = 64;
    localparam int KEY_W      = 80;
    localparam int KEY_LO_W   = 16;
    localparam int KEY_COUNT  = 32;
    localparam int CNT_W      = $clog2(KEY_COUNT);
    localparam int DEF_ROUNDS = 31;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 4;

    localparam logic REG_KEY_UPPER = 1'b0;
    localparam logic REG_KEY_LOWER = 1'b1;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    localparam logic [3:0] SBOX_FWD [16] = '{
        4'hC, 4'h5, 4'h6, 4'hB, 4'h9, 4'h0, 4'hA, 4'hD,
        4'h3, 4'hE, 4'hF, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
    };
    localparam logic [3:0] SBOX_INV [16] = '{
        4'h5, 4'hE, 4'hF, 4'h8, 4'hC, 4'h1, 4'h2, 4'hD,
        4'hB, 4'h4, 4'h6, 4'h3, 4'h0, 4'h7, 4'h9, 4'hA
    };

    typedef logic [KEY_COUNT-1:0][BLOCK_W-1:0] key_array_t;

    typedef struct packed {
        logic               valid;
        logic               dir;
        logic [BLOCK_W-1:0] data;
    } stage_t;

    function automatic logic [BLOCK_W-1:0] sbox_layer_fwd(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int i = 0; i < BLOCK_W / 4; i++) begin
            y[4*i +: 4] = SBOX_FWD[x[4*i +: 4]];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] sbox_layer_inv(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        for (int i = 0; i < BLOCK_W / 4; i++) begin
            y[4*i +: 4] = SBOX_INV[x[4*i +: 4]];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_layer_fwd(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y[BLOCK_W-1] = x[BLOCK_W-1];
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            y[(i * 16) % (BLOCK_W - 1)] = x[i];
        end
        return y;
    endfunction

    function automatic logic [BLOCK_W-1:0] perm_layer_inv(input logic [BLOCK_W-1:0] x);
        logic [BLOCK_W-1:0] y;
        y[BLOCK_W-1] = x[BLOCK_W-1];
        for (int i = 0; i < BLOCK_W - 1; i++) begin
            y[(i * 4) % (BLOCK_W - 1)] = x[i];
        end
        return y;
    endfunction

    function automatic logic [KEY_W-1:0] key_step(input logic [KEY_W-1:0] k,
                                                  input logic [CNT_W-1:0] ctr);
        logic [KEY_W-1:0] r;
        r          = {k[18:0], k[KEY_W-1:19]};
        r[79:76]   = SBOX_FWD[r[79:76]];
        r[19:15]   = r[19:15] ^ ctr;
        return r;
    endfunction

endpackage

// ----- src/prs80_key_sched.sv -----
// ----------------------------------------------------------------------------
// prs80_key_sched
// Key schedule sequencer: one round key per cycle into the round key store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs80_key_sched (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load_i,
    input  logic [prs80_pkg::KEY_W-1:0]   key_i,
    output logic                          busy_o,
    output prs80_pkg::key_array_t         round_keys_o
);
    import prs80_pkg::*;

    localparam logic [CNT_W-1:0] LAST = CNT_W'(KEY_COUNT - 1);

    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    key_array_t       store_reg;

    always_comb begin
        key_next  = key_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        priority if (load_i) begin
            key_next  = key_i;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg == LAST) begin
                busy_next = 1'b0;
            end else begin
                key_next = key_step(key_reg, cnt_reg + CNT_W'(1));
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg  <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
        end else begin
            key_reg  <= key_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg && !load_i) begin
            store_reg[cnt_reg] <= key_reg[KEY_W-1 -: BLOCK_W];
        end
    end

    assign busy_o       = busy_reg;
    assign round_keys_o = store_reg;

`ifndef SYNTHESIS
    a_sched_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && cnt_reg == LAST && !load_i) |=> !busy_reg)
        else $error("key schedule did not finish after last round key");
    a_sched_load: assert property (@(posedge aclk) disable iff (!aresetn)
        load_i |=> (busy_reg && cnt_reg == '0))
        else $error("key schedule did not restart on key load");
`endif

endmodule

// ----- src/prs80_round_cell.sv -----
// ----------------------------------------------------------------------------
// prs80_round_cell
// One cipher round, encrypt or inverse, registered toward the next cell.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prs80_round_cell (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv_i,
    input  prs80_pkg::stage_t               stage_i,
    input  logic [prs80_pkg::BLOCK_W-1:0]   enc_key_i,
    input  logic [prs80_pkg::BLOCK_W-1:0]   dec_key_i,
    output prs80_pkg::stage_t               stage_o
);
    import prs80_pkg::*;

    logic               valid_reg;
    logic               dir_reg;
    logic [BLOCK_W-1:0] data_reg;
    logic [BLOCK_W-1:0] data_next;

    always_comb begin
        unique case (stage_i.dir)
            DIR_DECRYPT: data_next = sbox_layer_inv(perm_layer_inv(stage_i.data)) ^ dec_key_i;
            default:     data_next = perm_layer_fwd(sbox_layer_fwd(stage_i.data ^ enc_key_i));
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv_i) begin
            valid_reg <= stage_i.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv_i && stage_i.valid) begin
            dir_reg  <= stage_i.dir;
            data_reg <= data_next;
        end
    end

    assign stage_o = '{valid: valid_reg, dir: dir_reg, data: data_reg};

endmodule

// ----- src/present80_block_cipher.sv -----
// ----------------------------------------------------------------------------
// present80_block_cipher
// PRESENT-80 ECB engine. Blocks pass through a chain of ROUNDS round cells, one
// cell per round, so a new block is taken every cycle while the round keys are ready
// and the result side does not stall; a stall on the result side holds the whole
// chain. The 80-bit key is written over APB (key_upper at 0x0, key_lower at 0x8).
// After reset and after every key write the key schedule sequencer derives the 32
// round keys one per cycle, and s_ready stays low until it is done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module present80_block_cipher #(
    parameter int ROUNDS = prs80_pkg::DEF_ROUNDS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [prs80_pkg::ADDR_W-1:0]    paddr,
    input  logic [prs80_pkg::DATA_W-1:0]    pwdata,
    output logic [prs80_pkg::DATA_W-1:0]    prdata,
    output logic                            pready,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_req_type,
    input  logic [prs80_pkg::BLOCK_W-1:0]   s_data_block,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [prs80_pkg::BLOCK_W-1:0]   m_result_block
);
    import prs80_pkg::*;

    logic [BLOCK_W-1:0]  key_upper_reg, key_upper_next;
    logic [KEY_LO_W-1:0] key_lower_reg, key_lower_next;
    logic                reg_sel;
    logic                cfg_wr;
    logic                sched_busy;
    logic                adv;
    key_array_t          round_keys;
    stage_t              stage_w [ROUNDS+1];
    logic [BLOCK_W-1:0]  final_key;

    assign pready  = 1'b1;
    assign reg_sel = paddr[ADDR_W-1];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        key_upper_next = key_upper_reg;
        key_lower_next = key_lower_reg;
        if (cfg_wr) begin
            unique case (reg_sel)
                REG_KEY_UPPER: key_upper_next = pwdata[BLOCK_W-1:0];
                default:       key_lower_next = pwdata[KEY_LO_W-1:0];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_upper_reg <= '0;
            key_lower_reg <= '0;
        end else begin
            key_upper_reg <= key_upper_next;
            key_lower_reg <= key_lower_next;
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_KEY_UPPER: prdata = DATA_W'(key_upper_reg);
            default:       prdata = DATA_W'(key_lower_reg);
        endcase
    end

    prs80_key_sched u_key_sched (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load_i       (cfg_wr),
        .key_i        ({key_upper_next, key_lower_next}),
        .busy_o       (sched_busy),
        .round_keys_o (round_keys)
    );

    assign final_key = round_keys[ROUNDS];
    assign adv       = !stage_w[ROUNDS].valid || m_ready;
    assign s_ready   = adv && !sched_busy;

    assign stage_w[0] = '{
        valid: s_valid && s_ready,
        dir:   s_req_type,
        data:  (s_req_type == DIR_DECRYPT) ? (s_data_block ^ final_key) : s_data_block
    };

    for (genvar i = 0; i < ROUNDS; i++) begin : g_cell
        prs80_round_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .adv_i     (adv),
            .stage_i   (stage_w[i]),
            .enc_key_i (round_keys[i]),
            .dec_key_i (round_keys[ROUNDS-1-i]),
            .stage_o   (stage_w[i+1])
        );
    end

    assign m_valid        = stage_w[ROUNDS].valid;
    assign m_result_block = (stage_w[ROUNDS].dir == DIR_DECRYPT) ? stage_w[ROUNDS].data
                                                                 : (stage_w[ROUNDS].data ^ final_key);

`ifndef SYNTHESIS
    a_no_take_in_sched: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !sched_busy)
        else $error("input taken while round keys are being derived");
    a_block_after_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_ready)
        else $error("input ready right after key write");
    a_stall_holds_in: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |-> !s_ready)
        else $error("input ready while result side stalls");
`endif

endmodule

// ----- tb/present80_block_cipher_tb.sv -----
// ----------------------------------------------------------------------------
// present80_block_cipher_tb
// Self-checking bench for the PRESENT-80 ECB engine. Keys are loaded over APB
// while the engine is idle. Blocks of both directions are sent through the
// valid/ready input channel, and each one's cipher result is predicted from a
// local copy of the key schedule. Results from the output channel are checked
// in order against those predictions. Both sides idle at random, and one long
// output stall fills the round chain. Runs cover the reset key, the all-ones
// key, masked key bits and a series of random keys.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module present80_block_cipher_tb;

    import prs80_pkg::*;

    localparam int          ROUND_COUNT   = DEF_ROUNDS;
    localparam logic [63:0] FWD_SUBST_TAB = 64'h2174_8FE3_DA09_B65C;
    localparam logic [63:0] INV_SUBST_TAB = 64'hA970_364B_D21C_8FE5;
    localparam logic [63:0] ZERO_KEY_CT   = 64'h5579_C138_7B22_8445;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [ADDR_W-1:0]     paddr;
    logic [DATA_W-1:0]     pwdata;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;
    logic                  s_valid;
    logic                  s_ready;
    logic                  s_req_type;
    logic [BLOCK_W-1:0]    s_data_block;
    logic                  m_valid;
    logic                  m_ready;
    logic [BLOCK_W-1:0]    m_result_block;

    logic [63:0] key_hi_q;
    logic [15:0] key_lo_q;
    logic [63:0] round_keys [0:31];
    logic [63:0] awaited_blocks [$];

    int mismatch_count = 0;
    int in_gap_max     = 0;
    int out_gap_max    = 0;
    int hold_cycles    = 0;

    present80_block_cipher dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_data_block   (s_data_block),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_block (m_result_block)
    );

    always #5 aclk = ~aclk;

    function automatic void expand_round_keys();
        logic [79:0] k;
        logic [4:0]  step_no;
        k = {key_hi_q, key_lo_q};
        for (int r = 0; r < 32; r++) begin
            round_keys[r] = k[79:16];
            step_no       = 5'(r + 1);
            k             = {k[18:0], k[79:19]};
            k[79:76]      = FWD_SUBST_TAB[{k[79:76], 2'b00} +: 4];
            k[19:15]      = k[19:15] ^ step_no;
        end
    endfunction

    function automatic logic [63:0] substitute(input logic [63:0] x, input logic [63:0] tab);
        logic [63:0] y;
        for (int i = 0; i < 16; i++) begin
            y[4*i +: 4] = tab[{x[4*i +: 4], 2'b00} +: 4];
        end
        return y;
    endfunction

    function automatic logic [63:0] permute(input logic [63:0] x, input int mult);
        logic [63:0] y;
        y     = '0;
        y[63] = x[63];
        for (int i = 0; i < 63; i++) begin
            y[(i * mult) % 63] = x[i];
        end
        return y;
    endfunction

    function automatic logic [63:0] cipher_block(input logic dir, input logic [63:0] blk);
        logic [63:0] b;
        b = blk;
        if (dir == DIR_DECRYPT) begin
            b = b ^ round_keys[ROUND_COUNT];
            for (int r = ROUND_COUNT; r > 0; r--) begin
                b = substitute(permute(b, 4), INV_SUBST_TAB) ^ round_keys[r-1];
            end
        end else begin
            for (int r = 0; r < ROUND_COUNT; r++) begin
                b = permute(substitute(b ^ round_keys[r], FWD_SUBST_TAB), 16);
            end
            b = b ^ round_keys[ROUND_COUNT];
        end
        return b;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Check every result transfer against the oldest prediction.
    always @(posedge aclk) begin : check_results
        logic [63:0] want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (awaited_blocks.size() == 0) begin
                report_mismatch("result with nothing pending", 'x, m_result_block);
            end else begin
                want = awaited_blocks.pop_front();
                if (m_result_block !== want) begin
                    report_mismatch("result_block", want, m_result_block);
                end
            end
        end
    end

    // Result side: idle a random number of cycles per transfer, or hold off long on request.
    initial begin : result_sink
        int gap;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            if (hold_cycles > 0) begin
                gap         = hold_cycles;
                hold_cycles = 0;
            end else begin
                gap = $urandom_range(0, out_gap_max);
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
        end
    end

    task automatic send_block(input logic dir, input logic [63:0] blk);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= dir;
        s_data_block <= blk;
        do @(posedge aclk); while (s_ready !== 1'b1);
        awaited_blocks.insert(awaited_blocks.size(), cipher_block(dir, blk));
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_blocks.size() != 0);
    endtask

    task automatic write_key(input logic reg_sel, input logic [63:0] value);
        logic [63:0] want_rd;
        do @(posedge aclk); while (s_ready !== 1'b1);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 3'b000};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_sel == REG_KEY_UPPER) begin
            key_hi_q = value;
            want_rd  = value;
        end else begin
            key_lo_q = value[15:0];
            want_rd  = {48'h0, value[15:0]};
        end
        expand_round_keys();
        // hold until the schedule rebuild has started
        do @(posedge aclk); while (s_ready === 1'b1);
        if (prdata !== want_rd) begin
            report_mismatch("prdata", want_rd, prdata);
        end
    endtask

    task automatic test_reset_key();
        send_block(DIR_ENCRYPT, 64'h0);
        send_block(DIR_ENCRYPT, '1);
        send_block(DIR_DECRYPT, 64'h0);
        send_block(DIR_DECRYPT, '1);
        send_block(DIR_DECRYPT, ZERO_KEY_CT);
        send_block(DIR_ENCRYPT, 64'h5555_5555_5555_5555);
        send_block(DIR_ENCRYPT, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(DIR_ENCRYPT, 64'h1);
        send_block(DIR_DECRYPT, 64'h8000_0000_0000_0000);
        wait_results_drained();
    endtask

    task automatic test_key_extremes();
        write_key(REG_KEY_UPPER, '1);
        write_key(REG_KEY_LOWER, '1);
        send_block(DIR_ENCRYPT, 64'h0);
        send_block(DIR_ENCRYPT, '1);
        send_block(DIR_DECRYPT, 64'h0);
        send_block(DIR_DECRYPT, '1);
        wait_results_drained();
        // upper bits of key_lower are dropped
        write_key(REG_KEY_UPPER, 64'h0123_4567_89AB_CDEF);
        write_key(REG_KEY_LOWER, 64'hFFFF_FFFF_FFFF_0000);
        send_block(DIR_ENCRYPT, 64'h0);
        send_block(DIR_DECRYPT, 64'hFEDC_BA98_7654_3210);
        wait_results_drained();
        write_key(REG_KEY_UPPER, 64'h0);
        write_key(REG_KEY_LOWER, 64'h0);
        send_block(DIR_ENCRYPT, 64'h0);
        send_block(DIR_DECRYPT, ZERO_KEY_CT);
        wait_results_drained();
    endtask

    task automatic test_random_traffic();
        int          in_gaps  [6] = '{12, 0, 3, 12, 0, 6};
        int          out_gaps [6] = '{12, 0, 12, 0, 3, 6};
        logic        dir;
        logic        prev_dir;
        logic [63:0] blk;
        logic [63:0] prev_result;
        prev_dir    = DIR_ENCRYPT;
        prev_result = '0;
        for (int phase = 0; phase < 6; phase++) begin
            wait_results_drained();
            if (phase % 3 != 2) begin
                write_key(REG_KEY_UPPER, {$urandom, $urandom});
            end
            if (phase % 3 != 1) begin
                write_key(REG_KEY_LOWER, {$urandom, $urandom});
            end
            in_gap_max  = in_gaps[phase];
            out_gap_max = out_gaps[phase];
            for (int n = 0; n < 300; n++) begin
                // a quarter of the blocks run the previous result back the other way
                if ($urandom_range(0, 3) == 0) begin
                    dir = ~prev_dir;
                    blk = prev_result;
                end else begin
                    dir = 1'($urandom_range(0, 1));
                    blk = {$urandom, $urandom};
                end
                send_block(dir, blk);
                prev_dir    = dir;
                prev_result = cipher_block(dir, blk);
            end
        end
        wait_results_drained();
    endtask

    task automatic test_output_stall();
        in_gap_max  = 0;
        out_gap_max = 0;
        hold_cycles = 300;
        for (int n = 0; n < 100; n++) begin
            send_block(1'($urandom_range(0, 1)), {$urandom, $urandom});
        end
        wait_results_drained();
        in_gap_max  = 4;
        out_gap_max = 4;
    endtask

    initial begin
        aresetn      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        s_valid      <= 1'b0;
        s_req_type   <= DIR_ENCRYPT;
        s_data_block <= '0;
        key_hi_q      = '0;
        key_lo_q      = '0;
        expand_round_keys();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        in_gap_max  = 2;
        out_gap_max = 2;
        test_reset_key();
        test_key_extremes();
        test_output_stall();
        test_random_traffic();

        wait_results_drained();
        repeat (ROUND_COUNT + 16) @(posedge aclk);
        if (awaited_blocks.size() != 0) begin
            $display("%0d results never arrived", awaited_blocks.size());
        end
        if (mismatch_count == 0 && awaited_blocks.size() == 0) begin
            $display("[present80_block_cipher] OK");
        end else begin
            $display("[present80_block_cipher] ERROR");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[present80_block_cipher] ERROR");
        $finish;
    end

endmodule
